// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// File: design/rwa_pkg.sv
// types and constants of the rolling window adler-32 block
package rwa_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int SUM_W  = 16;
    localparam int PROD_W = BYTE_W + LEN_W;

    localparam logic [SUM_W:0]   ADLER_MOD = 17'd65521;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd1024;
    localparam logic [SUM_W-1:0] A_RESET   = 16'd1;
    localparam logic [SUM_W-1:0] B_RESET   = 16'd0;

    // one item as seen by the sum update stage
    typedef struct packed {
        logic              restart;
        logic              roll;
        logic [BYTE_W-1:0] data_in;
        logic [BYTE_W-1:0] data_out;
        logic [SUM_W-1:0]  term;
    } upd_t;

endpackage

// File: design/rwa_if.sv
// valid/ready stream interfaces for input and result items
interface rwa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface rwa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;
    logic        window_full;

    modport source (output valid, output checksum, output window_full, input ready);
    modport sink   (input valid, input checksum, input window_full, output ready);
endinterface

// File: design/rwa_sum_unit.sv
// modular a/b sum registers and their per-item update
module rwa_sum_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd_en,
    input  rwa_pkg::upd_t             upd,
    output logic [rwa_pkg::SUM_W-1:0] a_next,
    output logic [rwa_pkg::SUM_W-1:0] b_next
);

    logic [rwa_pkg::SUM_W-1:0] sum_a_reg;
    logic [rwa_pkg::SUM_W-1:0] sum_b_reg;

    logic [rwa_pkg::SUM_W-1:0] a0;
    logic [rwa_pkg::SUM_W-1:0] b0;
    logic [17:0]               ta;
    logic [17:0]               tb;
    logic [17:0]               mod18;

    assign mod18 = 18'(rwa_pkg::ADLER_MOD);

    always_comb
    begin
        a0 = upd.restart ? rwa_pkg::A_RESET : sum_a_reg;
        b0 = upd.restart ? rwa_pkg::B_RESET : sum_b_reg;
        if (upd.roll)
        begin
            // a - out + in lies in [-255, 2M); one correction either way
            ta = 18'(a0) + 18'(upd.data_in) - 18'(upd.data_out);
            if (ta[17])
                ta = ta + mod18;
            else if (ta >= mod18)
                ta = ta - mod18;
            a_next = ta[rwa_pkg::SUM_W-1:0];
            // b - term + a_new - 1 lies in [-M, 2M)
            tb = 18'(b0) - 18'(upd.term) + 18'(a_next) - 18'd1;
            if (tb[17])
                tb = tb + mod18;
            else if (tb >= mod18)
                tb = tb - mod18;
            b_next = tb[rwa_pkg::SUM_W-1:0];
        end
        else
        begin
            ta = 18'(a0) + 18'(upd.data_in);
            if (ta >= mod18)
                ta = ta - mod18;
            a_next = ta[rwa_pkg::SUM_W-1:0];
            tb = 18'(b0) + 18'(a_next);
            if (tb >= mod18)
                tb = tb - mod18;
            b_next = tb[rwa_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= rwa_pkg::A_RESET;
            sum_b_reg <= rwa_pkg::B_RESET;
        end
        else if (upd_en)
        begin
            sum_a_reg <= a_next;
            sum_b_reg <= b_next;
        end
    end

endmodule

// File: design/rolling_window_adler32_top.sv
// top level of the rolling window adler-32 checksum block
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    data_byte[7:0], restart
//  out_ch    out  valid/ready    checksum[31:0], window_full
//  cfg       in   cfg_we         cfg_wdata[12:0] -> window_len
//
// one item per cycle sustained while out_ch keeps taking results; after its item is taken a result
// passes store read, multiply, reduce, and sum update into the output register
// the window store is written and read once per item through its single port pair
// reset clears sums, fill count, pointer and pipeline valids; the store is not cleared
// stalls on out_ch back up stage by stage, so bubbles are absorbed before in_ch stalls
module rolling_window_adler32_top
#(
    parameter int MAX_WINDOW = 4096
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rwa_pkg::LEN_W-1:0] cfg_wdata,
    rwa_in_if.sink                    in_ch,
    rwa_out_if.source                 out_ch
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (FILL_W > rwa_pkg::LEN_W) ? FILL_W : rwa_pkg::LEN_W;
    localparam logic [CMP_W-1:0] MAX_C    = CMP_W'(MAX_WINDOW);
    localparam logic [CMP_W:0]   MAX_X    = (CMP_W + 1)'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);

    // configuration and fill control
    logic [rwa_pkg::LEN_W-1:0]  window_len_reg;
    logic [FILL_W-1:0]          fill_count_reg;
    logic [FILL_W-1:0]          fill_count_next;
    logic [PTR_W-1:0]           wp_reg;
    logic [PTR_W-1:0]           wp_next;

    logic [CMP_W-1:0]           len_ext;
    logic [CMP_W-1:0]           len_eff;
    logic [CMP_W-1:0]           fc_eff;
    logic [CMP_W-1:0]           fc_new;
    logic                       roll;
    logic                       full;
    logic [CMP_W:0]             rd_diff;
    logic [PTR_W-1:0]           rd_addr;

    logic [rwa_pkg::BYTE_W-1:0] store_mem [MAX_WINDOW];

    // pipeline enables
    logic en1;
    logic en2;
    logic en3;
    logic en_out;
    logic in_fire;

    // stage 1: store read data returning
    logic                       v1_reg;
    logic [rwa_pkg::BYTE_W-1:0] rdata_reg;
    logic [rwa_pkg::BYTE_W-1:0] data1_reg;
    logic                       restart1_reg;
    logic                       roll1_reg;
    logic                       full1_reg;
    logic [rwa_pkg::LEN_W-1:0]  len1_reg;

    // stage 2: product
    logic                        v2_reg;
    logic [rwa_pkg::BYTE_W-1:0]  data2_reg;
    logic [rwa_pkg::BYTE_W-1:0]  out2_reg;
    logic                        restart2_reg;
    logic                        roll2_reg;
    logic                        full2_reg;
    logic [rwa_pkg::PROD_W-1:0]  prod2_reg;

    // stage 3: reduced term
    logic                        v3_reg;
    rwa_pkg::upd_t               upd3_reg;
    logic                        full3_reg;
    logic [rwa_pkg::SUM_W:0]     red;
    logic [rwa_pkg::SUM_W-1:0]   term_next;

    // output register
    logic                        out_valid_reg;
    logic [31:0]                 checksum_reg;
    logic                        full_out_reg;
    logic [rwa_pkg::SUM_W-1:0]   a_next;
    logic [rwa_pkg::SUM_W-1:0]   b_next;

    assign en_out  = !out_valid_reg || out_ch.ready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign in_fire = in_ch.valid && en1;

    assign in_ch.ready        = en1;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.checksum    = checksum_reg;
    assign out_ch.window_full = full_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_len_reg <= rwa_pkg::LEN_RESET;
        else if (cfg_we)
            window_len_reg <= cfg_wdata;
    end

    // effective length, roll decision and leaving-byte address
    always_comb
    begin
        len_ext = CMP_W'(window_len_reg);
        if (len_ext == '0)
            len_eff = CMP_W'(1);
        else if (len_ext > MAX_C)
            len_eff = MAX_C;
        else
            len_eff = len_ext;

        fc_eff = in_ch.restart ? '0 : CMP_W'(fill_count_reg);
        roll   = (fc_eff >= len_eff);
        fc_new = roll ? fc_eff : fc_eff + CMP_W'(1);
        full   = roll || (fc_new >= len_eff);
        fill_count_next = fc_new[FILL_W-1:0];

        rd_diff = (CMP_W + 1)'(wp_reg) - {1'b0, len_eff};
        if (rd_diff[CMP_W])
            rd_diff = rd_diff + MAX_X;
        rd_addr = rd_diff[PTR_W-1:0];

        wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            wp_reg         <= '0;
        end
        else if (in_fire)
        begin
            fill_count_reg <= fill_count_next;
            wp_reg         <= wp_next;
        end
    end

    // window store: write the new byte, read the leaving one (old data on a collision)
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_mem[wp_reg] <= in_ch.data_byte;
            rdata_reg         <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_ch.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data1_reg    <= in_ch.data_byte;
            restart1_reg <= in_ch.restart;
            roll1_reg    <= roll;
            full1_reg    <= full;
            len1_reg     <= len_eff[rwa_pkg::LEN_W-1:0];
        end
        if (en2 && v1_reg)
        begin
            data2_reg    <= data1_reg;
            out2_reg     <= rdata_reg;
            restart2_reg <= restart1_reg;
            roll2_reg    <= roll1_reg;
            full2_reg    <= full1_reg;
            prod2_reg    <= rwa_pkg::PROD_W'(rdata_reg) * rwa_pkg::PROD_W'(len1_reg);
        end
        if (en3 && v2_reg)
        begin
            upd3_reg.restart  <= restart2_reg;
            upd3_reg.roll     <= roll2_reg;
            upd3_reg.data_in  <= data2_reg;
            upd3_reg.data_out <= out2_reg;
            upd3_reg.term     <= term_next;
            full3_reg         <= full2_reg;
        end
    end

    // len*out mod 65521: 2^16 is 15 mod 65521, so fold the high bits once
    always_comb
    begin
        red = (rwa_pkg::SUM_W + 1)'(prod2_reg[rwa_pkg::SUM_W-1:0])
            + (rwa_pkg::SUM_W + 1)'({prod2_reg[rwa_pkg::PROD_W-1:rwa_pkg::SUM_W], 4'b0000})
            - (rwa_pkg::SUM_W + 1)'(prod2_reg[rwa_pkg::PROD_W-1:rwa_pkg::SUM_W]);
        if (red >= rwa_pkg::ADLER_MOD)
            red = red - rwa_pkg::ADLER_MOD;
        term_next = red[rwa_pkg::SUM_W-1:0];
    end

    rwa_sum_unit u_sum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (v3_reg && en_out),
        .upd    (upd3_reg),
        .a_next (a_next),
        .b_next (b_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v3_reg)
        begin
            checksum_reg <= {b_next, a_next};
            full_out_reg <= full3_reg;
        end
    end

endmodule

// File: design/rwa_checker.sv
// port-level checks for the rolling window adler-32 block, bound to the top level
`include "assert_macros.svh"

module rwa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] checksum,
    input logic        window_full
);

    // a waiting result is held until taken
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(checksum) && $stable(window_full))

    // with no result pending the whole pipeline can move, so input is open
    `ASSERT_SAME(a_in_open, !out_valid, in_ready)

    // both halves are reduced modulo 65521
    `ASSERT_SAME(a_sums_reduced, out_valid, (checksum[15:0] < 16'd65521) && (checksum[31:16] < 16'd65521))

    // a fresh result must come from an item that was taken on in_ch and passed the pipeline registers
    `ASSERT_NEXT(a_no_spurious, !out_valid && !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2), !out_valid || $past(in_valid && in_ready, 4))

endmodule

bind rolling_window_adler32_top rwa_checker u_rwa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .checksum    (out_ch.checksum),
    .window_full (out_ch.window_full)
);

// File: verif/tb_rolling_window_adler32_top.sv
// testbench for the rolling window adler-32 block: directed rows, random phases, checker
module tb_rolling_window_adler32_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HIST_DEPTH     = 4096;
    localparam int unsigned MOD_P          = int'(rwa_pkg::ADLER_MOD);
    localparam int          RAND_ITEMS     = 1800;
    localparam int          FLOOD_AFTER    = 600;
    localparam int          LONG_HOLD      = 400;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          NUM_DIR        = 19;

    typedef struct packed {
        logic [31:0] checksum;
        logic        window_full;
    } adler_res_t;

    typedef struct packed {
        logic       known;
        adler_res_t val;
    } typed_sum_t;

    typedef struct packed {
        logic                      set_len;
        logic [rwa_pkg::LEN_W-1:0] len;
        logic [7:0]                din;
        logic                      rs;
        logic                      known;
        logic [31:0]               checksum;
        logic                      window_full;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [rwa_pkg::LEN_W-1:0] cfg_wdata;

    rwa_in_if  in_ch ();
    rwa_out_if out_ch ();

    rolling_window_adler32_top #(
        .MAX_WINDOW (HIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [rwa_pkg::LEN_W-1:0] win_len  = rwa_pkg::LEN_RESET;
    logic [rwa_pkg::SUM_W-1:0] sum_a_q  = rwa_pkg::A_RESET;
    logic [rwa_pkg::SUM_W-1:0] sum_b_q  = rwa_pkg::B_RESET;
    logic [rwa_pkg::LEN_W-1:0] fill_q   = '0;
    logic [11:0]               wr_ptr   = '0;
    logic [7:0]                hist [HIST_DEPTH];

    adler_res_t pending_sums [$];
    typed_sum_t typed_sums [$];
    int         in_taken     = 0;
    int         out_taken    = 0;
    int         mismatches   = 0;
    int         stall_cycles = 0;
    logic       flood_req    = 1'b0;
    logic       flood_done   = 1'b0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{1'b0, 13'd0,    8'h00, 1'b0, 1'b1, 32'h00010001, 1'b0},
        '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b1, 32'h01010100, 1'b0},
        '{1'b0, 13'd0,    8'hFF, 1'b1, 1'b1, 32'h01000100, 1'b0},
        '{1'b1, 13'd1,    8'h07, 1'b1, 1'b1, 32'h00080008, 1'b1},
        '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b1, 32'h01000100, 1'b1},
        '{1'b1, 13'd0,    8'h00, 1'b0, 1'b1, 32'h00010001, 1'b1},
        '{1'b1, 13'h1FFF, 8'hFF, 1'b1, 1'b1, 32'h01000100, 1'b0},
        '{1'b1, 13'd4,    8'hFF, 1'b1, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'h00, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'h80, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'h01, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b1, 13'd2,    8'd10, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'd20, 1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b1, 13'd16,   8'd3,  1'b0, 1'b0, 32'h0,        1'b0},
        '{1'b0, 13'd0,    8'd200, 1'b0, 1'b0, 32'h0,       1'b0},
        '{1'b0, 13'd0,    8'h00, 1'b1, 1'b0, 32'h0,        1'b0},
        '{1'b1, 13'd4095, 8'd99, 1'b1, 1'b0, 32'h0,        1'b0}
    };

    // advances the window sums by one byte and returns the packed checksum
    function automatic adler_res_t adler_advance(logic [7:0] din, logic rs);
        int unsigned len;
        int unsigned wp;
        int unsigned rd;
        int unsigned leaving;
        int unsigned term;
        int unsigned sa;
        int unsigned sb;
        adler_res_t  res;
        len = win_len;
        if (len == 0)
            len = 1;
        if (len > HIST_DEPTH)
            len = HIST_DEPTH;
        wp = wr_ptr;
        if (rs)
        begin
            sum_a_q = rwa_pkg::A_RESET;
            sum_b_q = rwa_pkg::B_RESET;
            fill_q  = '0;
        end
        sa = sum_a_q;
        sb = sum_b_q;
        if (fill_q >= len)
        begin
            rd      = (wp >= len) ? (wp - len) : (wp + HIST_DEPTH - len);
            leaving = hist[rd];
            term    = ((len % MOD_P) * leaving) % MOD_P;
            sa      = (sa + MOD_P - leaving + din) % MOD_P;
            sb      = (sb + MOD_P - term + sa + MOD_P - 1) % MOD_P;
        end
        else
        begin
            sa = (sa + din) % MOD_P;
            sb = (sb + sa) % MOD_P;
            if (fill_q < HIST_DEPTH)
                fill_q = fill_q + 1'b1;
        end
        hist[wp] = din;
        wr_ptr   = wr_ptr + 1'b1;
        sum_a_q  = sa[rwa_pkg::SUM_W-1:0];
        sum_b_q  = sb[rwa_pkg::SUM_W-1:0];
        res.checksum    = {sum_b_q, sum_a_q};
        res.window_full = (fill_q >= len);
        return res;
    endfunction

    // predictor and checker, sampled at the rising edge
    always @(posedge clk)
    begin : checker_blk
        typed_sum_t hint;
        adler_res_t want;
        adler_res_t seen;
        if (rst_n)
        begin
            if (cfg_we)
                win_len = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
            begin
                hint = typed_sums.pop_front();
                want = adler_advance(in_ch.data_byte, in_ch.restart);
                if (hint.known)
                    want = hint.val;
                pending_sums.insert(pending_sums.size(), want);
                in_taken <= in_taken + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen.checksum    = out_ch.checksum;
                seen.window_full = out_ch.window_full;
                if (pending_sums.size() == 0)
                begin
                    $error("checksum item with no expected item: %h", seen.checksum);
                    mismatches++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (seen.checksum !== want.checksum)
                    begin
                        $error("checksum: expected %h, actual %h", want.checksum, seen.checksum);
                        mismatches++;
                    end
                    if (seen.window_full !== want.window_full)
                    begin
                        $error("window_full: expected %b, actual %b",
                               want.window_full, seen.window_full);
                        mismatches++;
                    end
                end
                out_taken <= out_taken + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("rolling_window_adler32_top regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // result side: own stall pattern, plus one long hold-off while the sender floods
    initial
    begin : result_side
        int mode;
        int cnt;
        logic held;
        mode = 0;
        cnt  = 0;
        held = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (flood_req && !held)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                flood_done <= 1'b1;
            end
            else
            begin
                if (cnt % 64 == 0)
                    mode = $urandom_range(0, 4);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= ($urandom_range(0, 9) != 0);
                    3: out_ch.ready <= ((cnt % 7) < 3);
                    default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
                cnt++;
                @(negedge clk);
            end
        end
    end

    int burst_left = 0;

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return 8'hFF;
        if (sel < 35)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // bursts of random length separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic offer(logic [7:0] din, logic rs, logic known, adler_res_t val);
        int         start;
        typed_sum_t entry;
        entry.known = known;
        entry.val   = val;
        typed_sums.insert(typed_sums.size(), entry);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= din;
        in_ch.restart   <= rs;
        start = in_taken;
        do
            @(negedge clk);
        while (in_taken == start);
    endtask

    task automatic wait_drained();
        while (pending_sums.size() != 0)
            @(negedge clk);
    endtask

    // window length is only written with the block empty
    task automatic write_len(logic [rwa_pkg::LEN_W-1:0] len);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [rwa_pkg::LEN_W-1:0] len, int n, int first_rs_pct);
        logic rs;
        write_len(len);
        for (int k = 0; k < n; k++)
        begin
            if (k == 0)
                rs = ($urandom_range(0, 99) < first_rs_pct);
            else
                rs = ($urandom_range(0, 49) == 0);
            pace();
            offer(pick_byte(), rs, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        int                        rand_sent;
        int                        sel;
        int                        n;
        logic                      flood_started;
        logic [rwa_pkg::LEN_W-1:0] len;
        rand_sent       = 0;
        flood_started   = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_len)
                write_len(dir_rows[i].len);
            pace();
            offer(dir_rows[i].din, dir_rows[i].rs, dir_rows[i].known,
                  '{dir_rows[i].checksum, dir_rows[i].window_full});
        end

        while (rand_sent < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                len = 13'($urandom_range(1, 32));
            else if (sel < 75)
                len = 13'($urandom_range(33, 300));
            else if (sel < 85)
                len = 13'($urandom_range(0, 1));
            else if (sel < 95)
                len = 13'($urandom_range(301, 8191));
            else
                len = 13'(HIST_DEPTH);
            n = $urandom_range(20, 150);
            run_phase(len, n, 70);
            rand_sent += n;
            if (rand_sent >= FLOOD_AFTER && !flood_started)
            begin
                // back-to-back items while the result side holds off
                flood_started = 1'b1;
                flood_req <= 1'b1;
                while (!flood_done)
                begin
                    offer(pick_byte(), 1'b0, 1'b0, '0);
                    rand_sent++;
                end
                flood_req <= 1'b0;
            end
        end

        // fill under a full-size window, then shrink mid-stream so it rolls at once
        run_phase(13'(HIST_DEPTH), 40, 0);
        run_phase(13'd0, 40, 0);

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("rolling_window_adler32_top regression: pass");
        else
            $display("rolling_window_adler32_top regression: fail");
        $finish;
    end

endmodule
